>>> rtl/snu_pkg.sv
// shared widths and constants for the surface normal unit
package snu_pkg;
    // default component and output fraction widths
    localparam int COMP_BITS_DEF     = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;
    // output word width
    localparam int OUT_W  = 16;
    // normalised magnitude: leading one at bit NORM_W-1
    localparam int NORM_W = 31;
    // sum of squares and its root
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;
    // square-root partial remainder
    localparam int REM_W  = ROOT_W + 3;
    // divisor width (twice the root)
    localparam int DEN_W  = ROOT_W + 1;
    // front-end stages ahead of the square root
    localparam int FRONT_STAGES = 7;
endpackage

>>> rtl/surface_normal_unit_top.sv
// surface normal unit: cross product of two vectors scaled to unit length
//
// One input word carries two 3-D vectors with signed Q1.15 components
// (s_a_*, s_b_*). One result word carries the unit normal of a x b in signed
// Q2.14, rounded to nearest with ties away from zero, and a degenerate flag
// that is set, with a zero normal, when the cross product is zero.
// Both channels use valid/ready handshakes.
// The pipe holds seven front stages (products, cross product, maximum,
// leading-one search, normalising shift, squares, sum), a 32-stage square
// root, one stage forming the dividends, OUT_FRAC_BITS+1 divider stages and
// the output register. A new word can be taken in every cycle while s_ready
// is high.
// All stages advance together; when the receiver holds m_ready low while a
// result is waiting, the whole pipe freezes and s_ready falls, and nothing is
// lost or repeated. Reset clears all valid bits; data registers hold no reset.
module surface_normal_unit_top
    import snu_pkg::*;
#(
    parameter int COMP_BITS     = COMP_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [COMP_BITS-1:0] s_a_x,
    input  logic signed [COMP_BITS-1:0] s_a_y,
    input  logic signed [COMP_BITS-1:0] s_a_z,
    input  logic signed [COMP_BITS-1:0] s_b_x,
    input  logic signed [COMP_BITS-1:0] s_b_y,
    input  logic signed [COMP_BITS-1:0] s_b_z,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [OUT_W-1:0]     m_norm_x,
    output logic signed [OUT_W-1:0]     m_norm_y,
    output logic signed [OUT_W-1:0]     m_norm_z,
    output logic                        m_degenerate
);
    localparam int PROD_W = 2 * COMP_BITS;
    localparam int MAG_W  = 2 * COMP_BITS;
    localparam int POS_W  = $clog2(MAG_W);
    localparam int Q_W    = OUT_FRAC_BITS + 1;
    localparam int NUM_W  = NORM_W + OUT_FRAC_BITS + 2;
    localparam int LAT    = FRONT_STAGES + ROOT_W + Q_W + 2;

    logic           en;
    logic [LAT-1:0] valid_reg;

    // global advance: the pipe moves unless a result is stuck at the output
    assign en      = !valid_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = valid_reg[LAT-1];

    // valid bits travel alongside the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], s_valid};
        end
    end

    // stage 1: the six products
    logic signed [PROD_W-1:0] p_reg [6];
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= PROD_W'(s_a_y * s_b_z);
            p_reg[1] <= PROD_W'(s_b_y * s_a_z);
            p_reg[2] <= PROD_W'(s_b_x * s_a_z);
            p_reg[3] <= PROD_W'(s_a_x * s_b_z);
            p_reg[4] <= PROD_W'(s_a_x * s_b_y);
            p_reg[5] <= PROD_W'(s_b_x * s_a_y);
        end
    end

    // stage 2: cross product, split into sign and magnitude
    logic signed [PROD_W:0] c_comb [3];
    logic [MAG_W-1:0]       u2_reg [3];
    logic [2:0]             neg2_reg;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_comb[i] = {p_reg[2*i][PROD_W-1], p_reg[2*i]}
                      - {p_reg[2*i+1][PROD_W-1], p_reg[2*i+1]};
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                neg2_reg[i] <= c_comb[i][PROD_W];
                u2_reg[i]   <= c_comb[i][PROD_W] ? MAG_W'(-c_comb[i])
                                                 : MAG_W'(c_comb[i]);
            end
        end
    end

    // stage 3: largest magnitude and zero test
    logic [MAG_W-1:0] mx_comb;
    logic [MAG_W-1:0] mx_reg;
    logic [MAG_W-1:0] u3_reg [3];
    logic [2:0]       neg3_reg;
    logic             zero3_reg;
    always_comb begin
        mx_comb = u2_reg[0];
        if (u2_reg[1] > mx_comb) mx_comb = u2_reg[1];
        if (u2_reg[2] > mx_comb) mx_comb = u2_reg[2];
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg    <= mx_comb;
            u3_reg    <= u2_reg;
            neg3_reg  <= neg2_reg;
            zero3_reg <= (mx_comb == '0);
        end
    end

    // stage 4: position of the leading one
    logic [POS_W-1:0] pos_comb;
    logic [POS_W-1:0] pos_reg;
    logic [MAG_W-1:0] u4_reg [3];
    logic [2:0]       neg4_reg;
    logic             zero4_reg;
    always_comb begin
        pos_comb = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (mx_reg[i]) pos_comb = POS_W'(i);
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg   <= pos_comb;
            u4_reg    <= u3_reg;
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    // stage 5: common shift bringing the largest into [2^30, 2^31)
    logic [MAG_W+NORM_W-2:0] sh_comb [3];
    logic [NORM_W-1:0]       u5_reg  [3];
    logic [2:0]              neg5_reg;
    logic                    zero5_reg;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sh_comb[i] = {u4_reg[i], {(NORM_W-1){1'b0}}} >> pos_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                u5_reg[i] <= sh_comb[i][NORM_W-1:0];
            end
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
        end
    end

    // stage 6: squares
    logic [2*NORM_W-1:0] sq_reg [3];
    logic [NORM_W-1:0]   u6_reg [3];
    logic [2:0]          neg6_reg;
    logic                zero6_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= u5_reg[i] * u5_reg[i];
            end
            u6_reg    <= u5_reg;
            neg6_reg  <= neg5_reg;
            zero6_reg <= zero5_reg;
        end
    end

    // stage 7: sum of squares
    logic [SUM_W-1:0]  sum_reg;
    logic [NORM_W-1:0] u7_reg [3];
    logic [2:0]        neg7_reg;
    logic              zero7_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            u7_reg    <= u6_reg;
            neg7_reg  <= neg6_reg;
            zero7_reg <= zero6_reg;
        end
    end

    // square root, with the magnitudes and flags delayed alongside
    logic [ROOT_W-1:0] root;
    snu_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .sum_in   (sum_reg),
        .root_out (root)
    );

    logic [NORM_W-1:0] dl_u_reg    [ROOT_W][3];
    logic [2:0]        dl_neg_reg  [ROOT_W];
    logic              dl_zero_reg [ROOT_W];
    always_ff @(posedge aclk) begin
        if (en) begin
            dl_u_reg[0]    <= u7_reg;
            dl_neg_reg[0]  <= neg7_reg;
            dl_zero_reg[0] <= zero7_reg;
            for (int k = 1; k < ROOT_W; k++) begin
                dl_u_reg[k]    <= dl_u_reg[k-1];
                dl_neg_reg[k]  <= dl_neg_reg[k-1];
                dl_zero_reg[k] <= dl_zero_reg[k-1];
            end
        end
    end

    // dividend u * 2^(frac+1) + m over divisor 2m
    logic [NUM_W-1:0] num_comb [3];
    logic [DEN_W-1:0] nhi_reg  [3];
    logic [Q_W-1:0]   nlo_reg  [3];
    logic [DEN_W-1:0] den_reg;
    logic [2:0]       negp_reg;
    logic             zerop_reg;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num_comb[i] = {1'b0, dl_u_reg[ROOT_W-1][i], {Q_W{1'b0}}}
                        + NUM_W'(root);
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                nhi_reg[i] <= DEN_W'(num_comb[i][NUM_W-1:Q_W]);
                nlo_reg[i] <= num_comb[i][Q_W-1:0];
            end
            den_reg   <= {root, 1'b0};
            negp_reg  <= dl_neg_reg[ROOT_W-1];
            zerop_reg <= dl_zero_reg[ROOT_W-1];
        end
    end

    // three dividers in parallel
    logic [Q_W-1:0] quot [3];
    for (genvar i = 0; i < 3; i++) begin : g_div
        snu_div #(
            .Q_W (Q_W)
        ) u_div (
            .aclk   (aclk),
            .en     (en),
            .num_hi (nhi_reg[i]),
            .num_lo (nlo_reg[i]),
            .den    (den_reg),
            .quot   (quot[i])
        );
    end

    logic [2:0] dq_neg_reg  [Q_W];
    logic       dq_zero_reg [Q_W];
    always_ff @(posedge aclk) begin
        if (en) begin
            dq_neg_reg[0]  <= negp_reg;
            dq_zero_reg[0] <= zerop_reg;
            for (int k = 1; k < Q_W; k++) begin
                dq_neg_reg[k]  <= dq_neg_reg[k-1];
                dq_zero_reg[k] <= dq_zero_reg[k-1];
            end
        end
    end

    // output register: apply the sign, zero a degenerate result
    logic [Q_W+OUT_W-1:0] qx_comb [3];
    logic [OUT_W-1:0]     res_comb [3];
    logic [OUT_W-1:0]     norm_reg [3];
    logic                 degen_reg;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qx_comb[i]  = {{OUT_W{1'b0}}, quot[i]};
            res_comb[i] = dq_neg_reg[Q_W-1][i] ? -qx_comb[i][OUT_W-1:0]
                                               : qx_comb[i][OUT_W-1:0];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                norm_reg[i] <= dq_zero_reg[Q_W-1] ? '0 : res_comb[i];
            end
            degen_reg <= dq_zero_reg[Q_W-1];
        end
    end

    assign m_norm_x     = norm_reg[0];
    assign m_norm_y     = norm_reg[1];
    assign m_norm_z     = norm_reg[2];
    assign m_degenerate = degen_reg;

    // a degenerate word always carries a zero normal
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_norm_x == '0 && m_norm_y == '0 && m_norm_z == '0)
        else $error("degenerate word with nonzero normal");

    // a frozen pipe keeps every valid bit in place
    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(valid_reg))
        else $error("valid bits moved during a stall");

    // an output word appears only from the stage before it
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(valid_reg[LAT-2]))
        else $error("output word without a source");
endmodule

>>> rtl/snu_isqrt.sv
// pipelined integer square root, one result bit per stage
module snu_isqrt
    import snu_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [SUM_W-1:0]  sum_in,
    output logic [ROOT_W-1:0] root_out
);
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SUM_W-1:0]  sh_reg   [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [SUM_W-1:0]  sh_prev;
        logic [REM_W-1:0]  rem_in;
        logic [REM_W-1:0]  trial;
        logic              ge;

        // previous stage or the incoming word
        if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign sh_prev   = sum_in;
        end else begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign sh_prev   = sh_reg[k-1];
        end

        // bring down two bits and try the next root bit
        assign rem_in = {rem_prev[REM_W-3:0], sh_prev[SUM_W-1 -: 2]};
        assign trial  = {1'b0, root_prev, 2'b01};
        assign ge     = rem_in >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? rem_in - trial : rem_in;
                root_reg[k] <= {root_prev[ROOT_W-2:0], ge};
                sh_reg[k]   <= {sh_prev[SUM_W-3:0], 2'b00};
            end
        end
    end

    assign root_out = root_reg[ROOT_W-1];
endmodule

>>> rtl/snu_div.sv
// pipelined restoring divider, one quotient bit per stage
module snu_div
    import snu_pkg::*;
#(
    parameter int Q_W = OUT_FRAC_BITS_DEF + 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [DEN_W-1:0] num_hi,
    input  logic [Q_W-1:0]   num_lo,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quot
);
    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   lo_reg  [Q_W];
    logic [Q_W-1:0]   q_reg   [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [DEN_W-1:0] rem_prev;
        logic [Q_W-1:0]   lo_prev;
        logic [Q_W-1:0]   q_prev;
        logic [DEN_W-1:0] den_prev;
        logic [DEN_W:0]   rem_in;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_prev = num_hi;
            assign lo_prev  = num_lo;
            assign q_prev   = '0;
            assign den_prev = den;
        end else begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign lo_prev  = lo_reg[k-1];
            assign q_prev   = q_reg[k-1];
            assign den_prev = den_reg[k-1];
        end

        // shift in the next dividend bit and subtract if it fits
        assign rem_in = {rem_prev, lo_prev[Q_W-1]};
        assign diff   = rem_in - {1'b0, den_prev};
        assign ge     = rem_in >= {1'b0, den_prev};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[DEN_W-1:0] : rem_in[DEN_W-1:0];
                lo_reg[k]  <= lo_prev << 1;
                q_reg[k]   <= {q_prev[Q_W-2:0], ge};
                den_reg[k] <= den_prev;
            end
        end
    end

    assign quot = q_reg[Q_W-1];
endmodule
